// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the segment intersection RTL.
// Depends on nothing; users provide clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SI_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define SI_CHECK_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define SI_CHECK(lbl, cond, msg)
`define SI_CHECK_IMP(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/segx_pkg.sv =====
// Types and constants for the segment intersection pipeline.
// No dependencies.
package segx_pkg;

    localparam int FIELD_BITS = 16;
    localparam int POINT_BITS = 24;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 8;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] first_start_x;
        logic signed [FIELD_BITS-1:0] first_start_y;
        logic signed [FIELD_BITS-1:0] first_end_x;
        logic signed [FIELD_BITS-1:0] first_end_y;
        logic signed [FIELD_BITS-1:0] second_start_x;
        logic signed [FIELD_BITS-1:0] second_start_y;
        logic signed [FIELD_BITS-1:0] second_end_x;
        logic signed [FIELD_BITS-1:0] second_end_y;
    } segx_in_t;

    typedef struct packed {
        logic                         intersects;
        logic                         no_unique_point;
        logic signed [POINT_BITS-1:0] point_x;
        logic signed [POINT_BITS-1:0] point_y;
    } segx_out_t;

    typedef struct packed {
        logic hit;
        logic nup;
    } segx_flags_t;

endpackage

// ===== rtl/segx_geom.sv =====
// Orientation front end: differences, cross products, signs, hit test.
// Depends on segx_pkg. Three register stages.
module segx_geom
    import segx_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  segx_in_t                      in_data,
    output logic                          out_valid,
    output logic signed [COORD_BITS-1:0]  x1,
    output logic signed [COORD_BITS-1:0]  y1,
    output logic signed [COORD_BITS:0]    dx1,
    output logic signed [COORD_BITS:0]    dy1,
    output logic signed [2*COORD_BITS+2:0] num,
    output logic signed [2*COORD_BITS+2:0] den,
    output segx_flags_t                   flags
);
    localparam int C  = COORD_BITS;
    localparam int PW = 2*C+2;
    localparam int DW = 2*C+3;

    function automatic logic in_box(
        input logic signed [C-1:0] ax, input logic signed [C-1:0] ay,
        input logic signed [C-1:0] bx, input logic signed [C-1:0] by,
        input logic signed [C-1:0] px, input logic signed [C-1:0] py);
        logic okx;
        logic oky;
        okx = (ax <= px && px <= bx) || (bx <= px && px <= ax);
        oky = (ay <= py && py <= by) || (by <= py && py <= ay);
        return okx && oky;
    endfunction

    logic [FIELD_BITS-1:0] f16 [8];
    logic signed [C-1:0] cr [8];

    assign f16[0] = in_data.first_start_x;
    assign f16[1] = in_data.first_start_y;
    assign f16[2] = in_data.first_end_x;
    assign f16[3] = in_data.first_end_y;
    assign f16[4] = in_data.second_start_x;
    assign f16[5] = in_data.second_start_y;
    assign f16[6] = in_data.second_end_x;
    assign f16[7] = in_data.second_end_y;

    for (genvar i = 0; i < 8; i++) begin : g_ext
        if (C <= FIELD_BITS) begin : g_narrow
            assign cr[i] = f16[i][C-1:0];
        end
        else begin : g_wide
            assign cr[i] = {{(C-FIELD_BITS){1'b0}}, f16[i]};
        end
    end

    // stage 1: differences and box tests
    logic                 v1_reg;
    logic signed [C-1:0]  s1_x1_reg, s1_y1_reg;
    logic signed [C:0]    s1_dx1_reg, s1_dy1_reg, s1_dx2_reg, s1_dy2_reg;
    logic signed [C:0]    s1_a_reg, s1_b_reg, s1_c_reg, s1_e_reg, s1_f_reg, s1_g_reg;
    logic [3:0]           s1_box_reg;

    function automatic logic signed [C:0] dif(input logic signed [C-1:0] p,
                                              input logic signed [C-1:0] q);
        return (C+1)'(p) - (C+1)'(q);
    endfunction

    always_ff @(posedge clk) begin
        if (en) begin
            s1_x1_reg  <= cr[0];
            s1_y1_reg  <= cr[1];
            s1_dx1_reg <= dif(cr[2], cr[0]);
            s1_dy1_reg <= dif(cr[3], cr[1]);
            s1_dx2_reg <= dif(cr[6], cr[4]);
            s1_dy2_reg <= dif(cr[7], cr[5]);
            s1_a_reg   <= dif(cr[0], cr[4]);
            s1_b_reg   <= dif(cr[1], cr[5]);
            s1_c_reg   <= dif(cr[2], cr[4]);
            s1_e_reg   <= dif(cr[3], cr[5]);
            s1_f_reg   <= dif(cr[6], cr[0]);
            s1_g_reg   <= dif(cr[7], cr[1]);
            s1_box_reg[0] <= in_box(cr[4], cr[5], cr[6], cr[7], cr[0], cr[1]);
            s1_box_reg[1] <= in_box(cr[4], cr[5], cr[6], cr[7], cr[2], cr[3]);
            s1_box_reg[2] <= in_box(cr[0], cr[1], cr[2], cr[3], cr[4], cr[5]);
            s1_box_reg[3] <= in_box(cr[0], cr[1], cr[2], cr[3], cr[6], cr[7]);
        end
    end

    // stage 2: products
    logic                 v2_reg;
    logic signed [C-1:0]  s2_x1_reg, s2_y1_reg;
    logic signed [C:0]    s2_dx1_reg, s2_dy1_reg;
    logic [3:0]           s2_box_reg;
    logic signed [PW-1:0] p_n1_reg, p_n0_reg, p_21_reg, p_20_reg;
    logic signed [PW-1:0] p_31_reg, p_30_reg, p_41_reg, p_40_reg, p_d1_reg, p_d0_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            s2_x1_reg  <= s1_x1_reg;
            s2_y1_reg  <= s1_y1_reg;
            s2_dx1_reg <= s1_dx1_reg;
            s2_dy1_reg <= s1_dy1_reg;
            s2_box_reg <= s1_box_reg;
            p_n1_reg   <= s1_b_reg * s1_dx2_reg;
            p_n0_reg   <= s1_a_reg * s1_dy2_reg;
            p_21_reg   <= s1_dx2_reg * s1_e_reg;
            p_20_reg   <= s1_dy2_reg * s1_c_reg;
            p_31_reg   <= s1_dy1_reg * s1_a_reg;
            p_30_reg   <= s1_dx1_reg * s1_b_reg;
            p_41_reg   <= s1_dx1_reg * s1_g_reg;
            p_40_reg   <= s1_dy1_reg * s1_f_reg;
            p_d1_reg   <= s1_dx1_reg * s1_dy2_reg;
            p_d0_reg   <= s1_dy1_reg * s1_dx2_reg;
        end
    end

    // stage 3: cross products, signs, hit
    logic signed [DW-1:0] c_num, c_2, c_3, c_4, c_den;
    logic o1p, o1n, o2p, o2n, o3p, o3n, o4p, o4n;
    logic hit_next;

    always_comb begin
        c_num = DW'(p_n1_reg) - DW'(p_n0_reg);
        c_2   = DW'(p_21_reg) - DW'(p_20_reg);
        c_3   = DW'(p_31_reg) - DW'(p_30_reg);
        c_4   = DW'(p_41_reg) - DW'(p_40_reg);
        c_den = DW'(p_d1_reg) - DW'(p_d0_reg);
        // first orientation is the numerator cross itself
        o1n = c_num[DW-1];
        o1p = !c_num[DW-1] && (c_num != '0);
        o2n = c_2[DW-1];
        o2p = !c_2[DW-1] && (c_2 != '0);
        o3n = c_3[DW-1];
        o3p = !c_3[DW-1] && (c_3 != '0);
        o4n = c_4[DW-1];
        o4p = !c_4[DW-1] && (c_4 != '0);
        hit_next = (((o1p && o2n) || (o1n && o2p)) && ((o3p && o4n) || (o3n && o4p)))
            || (!o1p && !o1n && s2_box_reg[0])
            || (!o2p && !o2n && s2_box_reg[1])
            || (!o3p && !o3n && s2_box_reg[2])
            || (!o4p && !o4n && s2_box_reg[3]);
    end

    logic v3_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            x1        <= s2_x1_reg;
            y1        <= s2_y1_reg;
            dx1       <= s2_dx1_reg;
            dy1       <= s2_dy1_reg;
            num       <= c_num;
            den       <= c_den;
            flags.hit <= hit_next;
            flags.nup <= (c_den == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;

endmodule

// ===== rtl/segx_pmul.sv =====
// Dividend build: base*den + delta*num for x and y, scaled and split into sign
// and magnitude. Depends on segx_pkg. Two register stages, split multiplies.
module segx_pmul
    import segx_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       en,
    input  logic                                       in_valid,
    input  logic signed [COORD_BITS-1:0]               x1,
    input  logic signed [COORD_BITS-1:0]               y1,
    input  logic signed [COORD_BITS:0]                 dx1,
    input  logic signed [COORD_BITS:0]                 dy1,
    input  logic signed [2*COORD_BITS+2:0]             num,
    input  logic signed [2*COORD_BITS+2:0]             den,
    input  segx_flags_t                                flags_in,
    output logic                                       out_valid,
    output logic [3*COORD_BITS+FRAC_BITS+4:0]          mag_x,
    output logic [3*COORD_BITS+FRAC_BITS+4:0]          mag_y,
    output logic                                       neg_x,
    output logic                                       neg_y,
    output logic [2*COORD_BITS+2:0]                    dmag,
    output segx_flags_t                                flags_out
);
    localparam int C   = COORD_BITS;
    localparam int DW  = 2*C+3;
    localparam int L   = (DW+1)/2;
    localparam int HW  = DW-L;
    localparam int NW  = C+DW+2;
    localparam int NSW = NW+FRAC_BITS;

    logic                   va_reg, vb_reg;
    logic signed [C+L:0]    pxbl_reg, pybl_reg;
    logic signed [C+HW-1:0] pxbh_reg, pybh_reg;
    logic signed [C+L+1:0]  pxdl_reg, pydl_reg;
    logic signed [C+HW:0]   pxdh_reg, pydh_reg;
    logic signed [DW-1:0]   den_a_reg;
    segx_flags_t            flags_a_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            pxbl_reg    <= x1 * $signed({1'b0, den[L-1:0]});
            pybl_reg    <= y1 * $signed({1'b0, den[L-1:0]});
            pxbh_reg    <= x1 * $signed(den[DW-1:L]);
            pybh_reg    <= y1 * $signed(den[DW-1:L]);
            pxdl_reg    <= dx1 * $signed({1'b0, num[L-1:0]});
            pydl_reg    <= dy1 * $signed({1'b0, num[L-1:0]});
            pxdh_reg    <= dx1 * $signed(num[DW-1:L]);
            pydh_reg    <= dy1 * $signed(num[DW-1:L]);
            den_a_reg   <= den;
            flags_a_reg <= flags_in;
        end
    end

    logic signed [NW-1:0]  nx, ny;
    logic signed [NSW-1:0] sx, sy;
    logic signed [DW-1:0]  dneg;

    always_comb begin
        nx = (NW'(pxbh_reg) <<< L) + NW'(pxbl_reg) + (NW'(pxdh_reg) <<< L) + NW'(pxdl_reg);
        ny = (NW'(pybh_reg) <<< L) + NW'(pybl_reg) + (NW'(pydh_reg) <<< L) + NW'(pydl_reg);
        sx = NSW'(nx) <<< FRAC_BITS;
        sy = NSW'(ny) <<< FRAC_BITS;
        dneg = -den_a_reg;
    end

    always_ff @(posedge clk) begin
        if (en) begin
            mag_x     <= sx[NSW-1] ? NSW'(-sx) : sx;
            mag_y     <= sy[NSW-1] ? NSW'(-sy) : sy;
            neg_x     <= sx[NSW-1] ^ den_a_reg[DW-1];
            neg_y     <= sy[NSW-1] ^ den_a_reg[DW-1];
            dmag      <= den_a_reg[DW-1] ? dneg : den_a_reg;
            flags_out <= flags_a_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    assign out_valid = vb_reg;

endmodule

// ===== rtl/segx_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, side tag carried.
// Depends on segx_pkg.
module segx_div
    import segx_pkg::*;
#(
    parameter int DW  = 2*COORD_BITS_DEF+3,
    parameter int QW  = COORD_BITS_DEF+FRAC_BITS_DEF+1,
    parameter int NSW = 3*COORD_BITS_DEF+FRAC_BITS_DEF+5,
    parameter int TW  = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [NSW-1:0] mag,
    input  logic [DW-1:0]  dvs,
    input  logic [TW-1:0]  tag_in,
    output logic           out_valid,
    output logic [QW-1:0]  quo,
    output logic [TW-1:0]  tag_out
);
    logic [DW-1:0] rem_reg [QW+1];
    logic [QW-1:0] lo_reg  [QW+1];
    logic [DW-1:0] d_reg   [QW+1];
    logic [TW-1:0] tag_reg [QW+1];
    logic [QW:0]   v_reg;

    // high dividend bits are below the divisor whenever the point is valid
    always_ff @(posedge clk) begin
        if (en) begin
            rem_reg[0] <= mag[QW+DW-1:QW];
            lo_reg[0]  <= mag[QW-1:0];
            d_reg[0]   <= dvs;
            tag_reg[0] <= tag_in;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [DW:0] t;
        logic [DW:0] diff;
        logic        ge;

        always_comb begin
            t    = {rem_reg[k-1], lo_reg[k-1][QW-1]};
            diff = t - {1'b0, d_reg[k-1]};
            ge   = (t >= {1'b0, d_reg[k-1]});
        end

        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
                lo_reg[k]  <= {lo_reg[k-1][QW-2:0], ge};
                d_reg[k]   <= d_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= '0;
        end
        else if (en) begin
            v_reg <= {v_reg[QW-1:0], in_valid};
        end
    end

    assign out_valid = v_reg[QW];
    assign quo       = lo_reg[QW];
    assign tag_out   = tag_reg[QW];

endmodule

// ===== rtl/segment_intersection.sv =====
// Top level of the segment intersection pipeline.
// Depends on segx_pkg, segx_geom, segx_pmul, segx_div and assert_macros.svh.
`include "assert_macros.svh"
// One transaction enters per clock while rsp is not stalled. Three stages
// form the orientation tests, two build the scaled dividend, the two
// coordinate dividers take one quotient bit per stage (COORD_BITS+FRAC_BITS+1
// stages plus a load stage), and the last stage holds the result. When rsp is
// stalled the whole pipeline holds.
module segment_intersection
    import segx_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  segx_in_t  req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output segx_out_t rsp
);
    localparam int C   = COORD_BITS;
    localparam int DW  = 2*C+3;
    localparam int QW  = C+FRAC_BITS+1;
    localparam int NSW = 3*C+FRAC_BITS+5;

    logic en;
    logic rsp_valid_reg;
    segx_out_t rsp_reg;

    assign en        = !rsp_valid_reg || rsp_ready;
    assign req_ready = en;

    logic                   g_valid;
    logic signed [C-1:0]    g_x1, g_y1;
    logic signed [C:0]      g_dx1, g_dy1;
    logic signed [DW-1:0]   g_num, g_den;
    segx_flags_t            g_flags;

    segx_geom #(.COORD_BITS(C)) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req_valid),
        .in_data   (req),
        .out_valid (g_valid),
        .x1        (g_x1),
        .y1        (g_y1),
        .dx1       (g_dx1),
        .dy1       (g_dy1),
        .num       (g_num),
        .den       (g_den),
        .flags     (g_flags)
    );

    logic             m_valid;
    logic [NSW-1:0]   m_mag_x, m_mag_y;
    logic             m_neg_x, m_neg_y;
    logic [DW-1:0]    m_dmag;
    segx_flags_t      m_flags;

    segx_pmul #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_pmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (g_valid),
        .x1        (g_x1),
        .y1        (g_y1),
        .dx1       (g_dx1),
        .dy1       (g_dy1),
        .num       (g_num),
        .den       (g_den),
        .flags_in  (g_flags),
        .out_valid (m_valid),
        .mag_x     (m_mag_x),
        .mag_y     (m_mag_y),
        .neg_x     (m_neg_x),
        .neg_y     (m_neg_y),
        .dmag      (m_dmag),
        .flags_out (m_flags)
    );

    logic          vx, vy;
    logic [QW-1:0] qx, qy;
    logic [2:0]    tx;
    logic          ty;

    segx_div #(.DW(DW), .QW(QW), .NSW(NSW), .TW(3)) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m_valid),
        .mag       (m_mag_x),
        .dvs       (m_dmag),
        .tag_in    ({m_flags, m_neg_x}),
        .out_valid (vx),
        .quo       (qx),
        .tag_out   (tx)
    );

    segx_div #(.DW(DW), .QW(QW), .NSW(NSW), .TW(1)) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m_valid),
        .mag       (m_mag_y),
        .dvs       (m_dmag),
        .tag_in    (m_neg_y),
        .out_valid (vy),
        .quo       (qy),
        .tag_out   (ty)
    );

    logic [POINT_BITS-1:0] qx24, qy24;

    if (QW >= POINT_BITS) begin : g_qtrunc
        assign qx24 = qx[POINT_BITS-1:0];
        assign qy24 = qy[POINT_BITS-1:0];
    end
    else begin : g_qext
        assign qx24 = {{(POINT_BITS-QW){1'b0}}, qx};
        assign qy24 = {{(POINT_BITS-QW){1'b0}}, qy};
    end

    segx_flags_t f_out;
    logic        point_ok;
    segx_out_t   rsp_next;

    always_comb begin
        f_out    = tx[2:1];
        point_ok = f_out.hit && !f_out.nup;
        rsp_next.intersects      = f_out.hit;
        rsp_next.no_unique_point = f_out.nup;
        rsp_next.point_x = point_ok ? (tx[0] ? -qx24 : qx24) : '0;
        rsp_next.point_y = point_ok ? (ty ? -qy24 : qy24) : '0;
    end

    always_ff @(posedge clk) begin
        if (en) begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_valid_reg <= 1'b0;
        end
        else if (en) begin
            rsp_valid_reg <= vx;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `SI_CHECK(a_lanes_aligned, vx == vy, "x and y divider lanes out of step")
    `SI_CHECK_IMP(a_nup_zero, rsp_valid && rsp.no_unique_point,
        rsp.point_x == '0 && rsp.point_y == '0, "point given without unique solution")
    `SI_CHECK_IMP(a_miss_zero, rsp_valid && !rsp.intersects,
        rsp.point_x == '0 && rsp.point_y == '0, "point given for non-intersecting segments")

endmodule
